FILE: design/text_console_writer_assert.svh
// ---------------------------------------------------------------------------
// text_console_writer assertion macros
// Shared concurrent assertion forms for the console controller and datapath.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Same-cycle implication.
`define TCW_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/tcw_pkg.sv
// ---------------------------------------------------------------------------
// tcw_pkg
// Constants, operation codes and control types of the text console writer.
// ---------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS_DEFAULT = 80;
  localparam int ROWS_DEFAULT    = 25;

  // Operation codes carried in s_tuser
  localparam int          FUNC_W      = 2;
  localparam logic [1:0]  FUNC_APPEND = 2'd0;
  localparam logic [1:0]  FUNC_CLEAR  = 2'd1;
  localparam logic [1:0]  FUNC_READ   = 2'd2;

  localparam logic [7:0]  NEWLINE_CODE = 8'd10;
  localparam logic [7:0]  BLANK_CHAR   = 8'h00;
  localparam logic [7:0]  BLANK_ATTR   = 8'h07;
  localparam int          CELL_W       = 16;
  localparam logic [15:0] BLANK_CELL   = {BLANK_ATTR, BLANK_CHAR};

  localparam int INDEX_W     = 11;
  localparam int OUT_ROW_W   = 5;
  localparam int OUT_COL_W   = 7;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 32;

  typedef struct packed {
    logic start;     // item transfer: execute the operation
    logic step;      // advance the cell sweep by one
    logic load_out;  // capture the result into the output register
  } tcw_cmd_t;

  typedef struct packed {
    logic pend;        // sweep write still in flight
    logic sweep_req;   // accepted item needs a clear or scroll sweep
    logic sweep_last;  // sweep is on its last cell
  } tcw_sts_t;

endpackage

FILE: design/tcw_ram.sv
// ---------------------------------------------------------------------------
// tcw_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/tcw_ctrl.sv
// ---------------------------------------------------------------------------
// tcw_ctrl
// Controller: sequences item execution, cell sweeps and result hand-off.
// ---------------------------------------------------------------------------
`include "text_console_writer_assert.svh"

module tcw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output tcw_pkg::tcw_cmd_t cmd,
  input  tcw_pkg::tcw_sts_t sts
);

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_SWEEP,
    ST_DONE
  } state_t;

  state_t state;

  assign s_tready = (state == ST_IDLE) && !sts.pend;

  always_comb begin
    cmd.start    = s_tvalid && s_tready;
    cmd.step     = (state == ST_INIT) || (state == ST_SWEEP);
    cmd.load_out = (state == ST_DONE) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        ST_INIT: begin
          if (sts.sweep_last) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd.start) begin
            state <= sts.sweep_req ? ST_SWEEP : ST_DONE;
          end
        end
        ST_SWEEP: begin
          if (sts.sweep_last) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (cmd.load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_INIT;
      endcase

      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  `TCW_ASSERT_IMPL(a_load_slot_free, clk, rst, cmd.load_out, !m_tvalid || m_tready,
                   "result overwritten")
  `TCW_ASSERT_NEXT(a_one_item_at_once, clk, rst, s_tvalid && s_tready, !s_tready,
                   "second item taken")

endmodule

FILE: design/tcw_datapath.sv
// ---------------------------------------------------------------------------
// tcw_datapath
// Datapath: cursor registers, cell store, sweep counter and result register.
// ---------------------------------------------------------------------------
`include "text_console_writer_assert.svh"

module tcw_datapath #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  tcw_pkg::tcw_cmd_t                  cmd,
  output tcw_pkg::tcw_sts_t                  sts,
  input  logic [tcw_pkg::IN_TDATA_W-1:0]     s_tdata,
  input  logic [tcw_pkg::FUNC_W-1:0]         s_tuser,
  output logic [tcw_pkg::OUT_TDATA_W-1:0]    m_tdata
);

  localparam int CellTotal   = COLUMNS * ROWS;
  localparam int AddrW       = $clog2(CellTotal);
  localparam int ColW        = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int RowW        = $clog2(ROWS);
  localparam int CopyEnd     = CellTotal - COLUMNS;
  localparam int LastRowBase = (ROWS - 1) * COLUMNS;

  logic [7:0]                   in_char;
  logic [7:0]                   in_attr;
  logic [tcw_pkg::INDEX_W-1:0]  in_index;
  logic [tcw_pkg::FUNC_W-1:0]   in_func;

  logic [RowW-1:0]  cur_row, cur_row_next;
  logic [ColW-1:0]  cur_col, cur_col_next;
  logic [AddrW-1:0] cur_addr, cur_addr_next;

  logic [AddrW-1:0] swp;
  logic             swp_scroll;
  logic             swp_copy;
  logic             pend_we;
  logic             pend_copy;
  logic [AddrW-1:0] pend_addr;
  logic             rd_hit;

  logic             at_last_col, at_last_row;
  logic             is_append, is_newline, is_put, is_read_hit, overflow;

  logic                  ram_we, ram_re;
  logic [AddrW-1:0]      ram_waddr, ram_raddr;
  logic [tcw_pkg::CELL_W-1:0] ram_wdata, ram_rdata;
  logic [7:0]            out_char, out_attr;

  assign in_char  = s_tdata[7:0];
  assign in_attr  = s_tdata[15:8];
  assign in_index = s_tdata[26:16];
  assign in_func  = s_tuser;

  assign at_last_col = (cur_col == ColW'(COLUMNS - 1));
  assign at_last_row = (cur_row == RowW'(ROWS - 1));
  assign is_append   = (in_func == tcw_pkg::FUNC_APPEND);
  assign is_newline  = is_append && (in_char == tcw_pkg::NEWLINE_CODE);
  assign is_put      = is_append && !is_newline;
  assign overflow    = is_append && at_last_row && (is_newline || at_last_col);
  assign is_read_hit = (in_func == tcw_pkg::FUNC_READ) && (int'(in_index) < CellTotal);
  assign swp_copy    = swp_scroll && (int'(swp) < CopyEnd);

  assign sts.pend       = pend_we;
  assign sts.sweep_req  = (in_func == tcw_pkg::FUNC_CLEAR) || overflow;
  assign sts.sweep_last = (swp == AddrW'(CellTotal - 1));

  // Cursor advance
  always_comb begin
    cur_row_next  = cur_row;
    cur_col_next  = cur_col;
    cur_addr_next = cur_addr;
    if (cmd.start) begin
      priority if (in_func == tcw_pkg::FUNC_CLEAR) begin
        cur_row_next  = '0;
        cur_col_next  = '0;
        cur_addr_next = '0;
      end else if (overflow) begin
        cur_row_next  = RowW'(ROWS - 1);
        cur_col_next  = '0;
        cur_addr_next = AddrW'(LastRowBase);
      end else if (is_newline) begin
        cur_row_next  = cur_row + 1'b1;
        cur_col_next  = '0;
        cur_addr_next = cur_addr + AddrW'(COLUMNS) - AddrW'(cur_col);
      end else if (is_put) begin
        if (at_last_col) begin
          cur_row_next = cur_row + 1'b1;
          cur_col_next = '0;
        end else begin
          cur_col_next = cur_col + 1'b1;
        end
        cur_addr_next = cur_addr + 1'b1;
      end else begin
        // read and unused codes: hold the cursor
      end
    end
  end

  // Store ports: each sweep write lands in the cycle after its read
  always_comb begin
    ram_we    = pend_we || (cmd.start && is_put);
    ram_waddr = pend_we ? pend_addr : cur_addr;
    if (pend_we) begin
      ram_wdata = pend_copy ? ram_rdata : tcw_pkg::BLANK_CELL;
    end else begin
      ram_wdata = {in_attr, in_char};
    end
    ram_re    = (cmd.start && is_read_hit) || (cmd.step && swp_copy);
    ram_raddr = cmd.step ? (swp + AddrW'(COLUMNS)) : AddrW'(in_index);
  end

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (CellTotal)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row    <= '0;
      cur_col    <= '0;
      cur_addr   <= '0;
      swp        <= '0;
      swp_scroll <= 1'b0;
      pend_we    <= 1'b0;
      rd_hit     <= 1'b0;
    end else begin
      cur_row  <= cur_row_next;
      cur_col  <= cur_col_next;
      cur_addr <= cur_addr_next;
      pend_we  <= cmd.step;
      if (cmd.start) begin
        swp        <= '0;
        swp_scroll <= (in_func != tcw_pkg::FUNC_CLEAR);
        rd_hit     <= is_read_hit;
      end else if (cmd.step) begin
        swp <= swp + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      pend_addr <= swp;
      pend_copy <= swp_copy;
    end
  end

  assign out_char = rd_hit ? ram_rdata[7:0]  : 8'h00;
  assign out_attr = rd_hit ? ram_rdata[15:8] : 8'h00;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {4'b0000, out_attr, out_char,
                  tcw_pkg::OUT_COL_W'(cur_col), tcw_pkg::OUT_ROW_W'(cur_row)};
    end
  end

  `TCW_ASSERT_IMPL(a_write_port_free, clk, rst, pend_we, !cmd.start, "store write clash")
  `TCW_ASSERT_IMPL(a_cursor_range, clk, rst, 1'b1,
                   (int'(cur_row) < ROWS) && (int'(cur_col) < COLUMNS),
                   "cursor out of range")
  `TCW_ASSERT_IMPL(a_cursor_addr, clk, rst, 1'b1,
                   int'(cur_addr) == int'(cur_row) * COLUMNS + int'(cur_col),
                   "cursor offset mismatch")

endmodule

FILE: design/text_console_writer.sv
// ---------------------------------------------------------------------------
// text_console_writer
// Text console: cell store with cursor, append/newline/scroll, clear, read.
// ---------------------------------------------------------------------------
// Result: after the input transfer the controller enters its done state, which loads the
// output register once the output slot is free; a scroll or clear passes through the sweep
// state first. A new item is taken only after the last result is loaded. A scroll or clear
// sweeps the store one cell a cycle. Reset: a sweep blanks every cell (char 0, attr 0x07)
// through the single RAM write port; s_tready stays low until it completes.
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [tcw_pkg::IN_TDATA_W-1:0]  s_tdata,   // char_code[7:0], attr[15:8],
                                                     // cell_index[26:16], zero fill
  input  logic [tcw_pkg::FUNC_W-1:0]      s_tuser,   // func[1:0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [tcw_pkg::OUT_TDATA_W-1:0] m_tdata    // cursor_row[4:0], cursor_col[11:5],
                                                     // read_char[19:12], read_attr[27:20]
);

  tcw_pkg::tcw_cmd_t cmd;
  tcw_pkg::tcw_sts_t sts;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .sts     (sts),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tdata (m_tdata)
  );

endmodule
